>>> design/ppc_pkg.sv
// ----------------------------------------------------------------------------
// ppc_pkg
// Shared types and constants of the pedal plausibility checker: register
// indexes and reset values, status codes, sequencer states and lane control.
// ----------------------------------------------------------------------------
package ppc_pkg;

    // Default width of every sensor count field
    localparam int COUNT_BITS = 16;

    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_IDX_BITS  = 3;
    localparam int PCT_BITS      = 7;
    localparam int PAIR_BITS     = 14;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_T1_SPAN     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_T1_WINDOW   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_T2_SPAN     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_T2_WINDOW   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_BRAKE_WIN   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_MISMATCH    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_INHIBIT     = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_RECOVER     = 3'd7;

    // Register reset values
    localparam logic [CFG_DATA_BITS-1:0] RST_T1_SPAN   = 32'd91228665;
    localparam logic [CFG_DATA_BITS-1:0] RST_T1_WINDOW = 32'd33558724;
    localparam logic [CFG_DATA_BITS-1:0] RST_T2_SPAN   = 32'd45091225;
    localparam logic [CFG_DATA_BITS-1:0] RST_T2_WINDOW = 32'd33689641;
    localparam logic [CFG_DATA_BITS-1:0] RST_BRAKE_WIN = 32'd17173374;
    localparam logic [PCT_BITS-1:0]      RST_MISMATCH  = 7'd10;
    localparam logic [PAIR_BITS-1:0]     RST_INHIBIT   = 14'd3215;
    localparam logic [PAIR_BITS-1:0]     RST_RECOVER   = 14'd645;

    // Result status codes
    localparam logic [1:0] ST_PLAUSIBLE   = 2'd0;
    localparam logic [1:0] ST_IMPLAUSIBLE = 2'd1;
    localparam logic [1:0] ST_ERRONEOUS   = 2'd2;

    localparam logic [PCT_BITS-1:0] FULL_PCT = 7'd100;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LANE = 5'b00010,
        S_MULA = 5'b00100,
        S_MULB = 5'b01000,
        S_DEC  = 5'b10000
    } state_t;

    // Load strobes from the sequencer to the lanes and the merge stage
    typedef struct packed {
        logic lane_ld;
        logic mul_ld;
        logic cmp_ld;
    } ctrl_t;

endpackage

>>> design/ppc_window_lane.sv
// ----------------------------------------------------------------------------
// ppc_window_lane
// One sensor lane: checks a count against its absolute min/max window.
// ----------------------------------------------------------------------------
module ppc_window_lane #(
    parameter int CB = ppc_pkg::COUNT_BITS
) (
    input  logic                              aclk,
    input  logic                              load,
    input  logic [CB-1:0]                     count,
    input  logic [ppc_pkg::CFG_DATA_BITS-1:0] window,
    output logic                              fail
);

    logic [CB-1:0] win_min;
    logic [CB-1:0] win_max;
    logic          fail_reg;
    logic          fail_next;

    assign win_min   = window[16 +: CB];
    assign win_max   = window[0 +: CB];
    assign fail_next = (count < win_min) || (count > win_max);

    always_ff @(posedge aclk) begin
        if (load) begin
            fail_reg <= fail_next;
        end
    end

    assign fail = fail_reg;

endmodule

>>> design/ppc_ratio_lane.sv
// ----------------------------------------------------------------------------
// ppc_ratio_lane
// One sensor lane: turns a count into a clamped ratio num/den over a
// zero/full span. A reversed or flat span never reaches the division case.
// ----------------------------------------------------------------------------
module ppc_ratio_lane #(
    parameter int CB = ppc_pkg::COUNT_BITS
) (
    input  logic                              aclk,
    input  logic                              load,
    input  logic [CB-1:0]                     count,
    input  logic [ppc_pkg::CFG_DATA_BITS-1:0] span,
    output logic [CB-1:0]                     num,
    output logic [CB-1:0]                     den
);

    logic [CB-1:0] zero_cnt;
    logic [CB-1:0] full_cnt;
    logic [CB-1:0] num_reg;
    logic [CB-1:0] num_next;
    logic [CB-1:0] den_reg;
    logic [CB-1:0] den_next;

    assign zero_cnt = span[16 +: CB];
    assign full_cnt = span[0 +: CB];

    always_comb begin
        if (count <= zero_cnt) begin
            num_next = '0;
            den_next = CB'(1);
        end else if (count >= full_cnt) begin
            num_next = CB'(1);
            den_next = CB'(1);
        end else begin
            num_next = count - zero_cnt;
            den_next = full_cnt - zero_cnt;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            num_reg <= num_next;
            den_reg <= den_next;
        end
    end

    assign num = num_reg;
    assign den = den_reg;

endmodule

>>> design/ppc_merge.sv
// ----------------------------------------------------------------------------
// ppc_merge
// Combines the lane results: cross-multiplies the ratios, compares against
// the percent thresholds and decides the latch, torque flag and status.
// ----------------------------------------------------------------------------
module ppc_merge #(
    parameter int CB = ppc_pkg::COUNT_BITS
) (
    input  logic                          aclk,
    input  ppc_pkg::ctrl_t                ctrl,
    input  logic [3:0]                    win_fail,
    input  logic [CB-1:0]                 t1_num,
    input  logic [CB-1:0]                 t1_den,
    input  logic [CB-1:0]                 t2_num,
    input  logic [CB-1:0]                 t2_den,
    input  logic [CB-1:0]                 br_num,
    input  logic [CB-1:0]                 br_den,
    input  logic [ppc_pkg::PCT_BITS-1:0]  limit_pct,
    input  logic [ppc_pkg::PAIR_BITS-1:0] inhibit_pair,
    input  logic [ppc_pkg::PAIR_BITS-1:0] recover_pair,
    input  logic                          latched,
    output logic                          latched_next,
    output logic                          torque_ok,
    output logic [1:0]                    status
);

    localparam int PW = 2 * CB;
    localparam int LW = PW + ppc_pkg::PCT_BITS;
    localparam int SW = CB + ppc_pkg::PCT_BITS;

    // Stage A: products
    logic [PW-1:0] lhs_reg;
    logic [PW-1:0] rhs_reg;
    logic [PW-1:0] dd_reg;
    logic [SW-1:0] t100_reg;
    logic [SW-1:0] tinh_reg;
    logic [SW-1:0] trec_reg;
    logic [SW-1:0] b100_reg;
    logic [SW-1:0] binh_reg;
    logic [SW-1:0] brec_reg;

    // Stage B: difference, limit and percent compares
    logic [PW-1:0] diff_reg;
    logic [LW-1:0] lim_reg;
    logic          thr_above_reg;
    logic          brk_above_reg;
    logic          thr_below_reg;
    logic          brk_below_reg;

    logic [LW-1:0] diff_scaled;
    logic          mis_fail;
    logic          press_fail;
    logic          keep_latch;

    always_ff @(posedge aclk) begin
        if (ctrl.mul_ld) begin
            lhs_reg  <= PW'(t1_num) * PW'(t2_den);
            rhs_reg  <= PW'(t2_num) * PW'(t1_den);
            dd_reg   <= PW'(t1_den) * PW'(t2_den);
            t100_reg <= SW'(t1_num) * SW'(ppc_pkg::FULL_PCT);
            tinh_reg <= SW'(inhibit_pair[13:7]) * SW'(t1_den);
            trec_reg <= SW'(recover_pair[13:7]) * SW'(t1_den);
            b100_reg <= SW'(br_num) * SW'(ppc_pkg::FULL_PCT);
            binh_reg <= SW'(inhibit_pair[6:0]) * SW'(br_den);
            brec_reg <= SW'(recover_pair[6:0]) * SW'(br_den);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.cmp_ld) begin
            diff_reg      <= (lhs_reg > rhs_reg) ? (lhs_reg - rhs_reg) : (rhs_reg - lhs_reg);
            lim_reg       <= LW'(limit_pct) * LW'(dd_reg);
            thr_above_reg <= t100_reg > tinh_reg;
            brk_above_reg <= b100_reg > binh_reg;
            thr_below_reg <= t100_reg < trec_reg;
            brk_below_reg <= b100_reg < brec_reg;
        end
    end

    assign diff_scaled = LW'(diff_reg) * LW'(ppc_pkg::FULL_PCT);
    assign mis_fail    = diff_scaled > lim_reg;
    assign press_fail  = thr_above_reg && brk_above_reg;
    // Latch holds unless both pedals are under their recovery levels
    assign keep_latch  = latched && !(thr_below_reg && brk_below_reg);

    always_comb begin
        if (|win_fail) begin
            latched_next = 1'b1;
            torque_ok    = 1'b0;
            status       = ppc_pkg::ST_ERRONEOUS;
        end else if (mis_fail || press_fail) begin
            latched_next = 1'b1;
            torque_ok    = 1'b0;
            status       = ppc_pkg::ST_IMPLAUSIBLE;
        end else begin
            latched_next = keep_latch;
            torque_ok    = !keep_latch;
            status       = keep_latch ? ppc_pkg::ST_IMPLAUSIBLE : ppc_pkg::ST_PLAUSIBLE;
        end
    end

endmodule

>>> design/pedal_plausibility_checker_core.sv
// ----------------------------------------------------------------------------
// pedal_plausibility_checker_core
// Throttle/brake pedal plausibility check with a latched torque inhibit.
//
//   Channel  | Ports                                   | Direction
//   ---------+-----------------------------------------+----------
//   input    | s_valid/s_ready, four sensor counts     | in
//   result   | m_valid/m_ready, torque_allowed, status | out
//   config   | cfg_wr_en, cfg_index, cfg_wr_data       | in
//
// A transaction steps through accept, lane load, multiply, compare and
// decide in that order, as the sequencer sets it.
// A new transaction is taken the cycle after the decide step.
// The decide step waits while an earlier result is still held on m_*.
// Reset (aresetn low, synchronous) restores register defaults, the latch, the sequencer and m_valid.
// ----------------------------------------------------------------------------
module pedal_plausibility_checker_core #(
    parameter int COUNT_BITS = ppc_pkg::COUNT_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [15:0]                         s_throttle1_count,
    input  logic [15:0]                         s_throttle2_count,
    input  logic [15:0]                         s_brake1_count,
    input  logic [15:0]                         s_brake2_count,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_torque_allowed,
    output logic [1:0]                          m_plaus_status,
    input  logic                                cfg_wr_en,
    input  logic [ppc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [ppc_pkg::CFG_DATA_BITS-1:0]   cfg_wr_data
);

    localparam int CB = COUNT_BITS;

    ppc_pkg::state_t state_reg;
    ppc_pkg::state_t state_next;
    ppc_pkg::ctrl_t  ctrl;

    logic [ppc_pkg::CFG_DATA_BITS-1:0] t1_span_reg;
    logic [ppc_pkg::CFG_DATA_BITS-1:0] t1_win_reg;
    logic [ppc_pkg::CFG_DATA_BITS-1:0] t2_span_reg;
    logic [ppc_pkg::CFG_DATA_BITS-1:0] t2_win_reg;
    logic [ppc_pkg::CFG_DATA_BITS-1:0] br_win_reg;
    logic [ppc_pkg::PCT_BITS-1:0]      limit_reg;
    logic [ppc_pkg::PAIR_BITS-1:0]     inhibit_reg;
    logic [ppc_pkg::PAIR_BITS-1:0]     recover_reg;

    logic [CB-1:0] t1_cnt_reg;
    logic [CB-1:0] t2_cnt_reg;
    logic [CB-1:0] b1_cnt_reg;
    logic [CB-1:0] b2_cnt_reg;

    logic [3:0]    win_fail;
    logic [CB-1:0] t1_num;
    logic [CB-1:0] t1_den;
    logic [CB-1:0] t2_num;
    logic [CB-1:0] t2_den;
    logic [CB-1:0] br_num;
    logic [CB-1:0] br_den;

    logic       latch_reg;
    logic       latch_next;
    logic       torque_ok;
    logic [1:0] status;

    logic       m_valid_reg;
    logic       m_valid_next;
    logic       torque_reg;
    logic [1:0] status_reg;

    logic s_accept;
    logic out_free;
    logic decide;

    assign s_ready  = (state_reg == ppc_pkg::S_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign decide   = (state_reg == ppc_pkg::S_DEC) && out_free;

    assign ctrl.lane_ld = (state_reg == ppc_pkg::S_LANE);
    assign ctrl.mul_ld  = (state_reg == ppc_pkg::S_MULA);
    assign ctrl.cmp_ld  = (state_reg == ppc_pkg::S_MULB);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_span_reg <= ppc_pkg::RST_T1_SPAN;
            t1_win_reg  <= ppc_pkg::RST_T1_WINDOW;
            t2_span_reg <= ppc_pkg::RST_T2_SPAN;
            t2_win_reg  <= ppc_pkg::RST_T2_WINDOW;
            br_win_reg  <= ppc_pkg::RST_BRAKE_WIN;
            limit_reg   <= ppc_pkg::RST_MISMATCH;
            inhibit_reg <= ppc_pkg::RST_INHIBIT;
            recover_reg <= ppc_pkg::RST_RECOVER;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ppc_pkg::REG_T1_SPAN: begin
                    t1_span_reg <= cfg_wr_data;
                end
                ppc_pkg::REG_T1_WINDOW: begin
                    t1_win_reg <= cfg_wr_data;
                end
                ppc_pkg::REG_T2_SPAN: begin
                    t2_span_reg <= cfg_wr_data;
                end
                ppc_pkg::REG_T2_WINDOW: begin
                    t2_win_reg <= cfg_wr_data;
                end
                ppc_pkg::REG_BRAKE_WIN: begin
                    br_win_reg <= cfg_wr_data;
                end
                ppc_pkg::REG_MISMATCH: begin
                    limit_reg <= cfg_wr_data[ppc_pkg::PCT_BITS-1:0];
                end
                ppc_pkg::REG_INHIBIT: begin
                    inhibit_reg <= cfg_wr_data[ppc_pkg::PAIR_BITS-1:0];
                end
                ppc_pkg::REG_RECOVER: begin
                    recover_reg <= cfg_wr_data[ppc_pkg::PAIR_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Capture the snapshot, low COUNT_BITS of each count
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            t1_cnt_reg <= s_throttle1_count[CB-1:0];
            t2_cnt_reg <= s_throttle2_count[CB-1:0];
            b1_cnt_reg <= s_brake1_count[CB-1:0];
            b2_cnt_reg <= s_brake2_count[CB-1:0];
        end
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ppc_pkg::S_IDLE: begin
                if (s_accept) begin
                    state_next = ppc_pkg::S_LANE;
                end
            end
            ppc_pkg::S_LANE: begin
                state_next = ppc_pkg::S_MULA;
            end
            ppc_pkg::S_MULA: begin
                state_next = ppc_pkg::S_MULB;
            end
            ppc_pkg::S_MULB: begin
                state_next = ppc_pkg::S_DEC;
            end
            ppc_pkg::S_DEC: begin
                if (out_free) begin
                    state_next = ppc_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ppc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ppc_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Window lanes: throttle 1, throttle 2, brake 1, brake 2
    ppc_window_lane #(.CB(CB)) u_win_t1 (
        .aclk   (aclk),
        .load   (ctrl.lane_ld),
        .count  (t1_cnt_reg),
        .window (t1_win_reg),
        .fail   (win_fail[0])
    );

    ppc_window_lane #(.CB(CB)) u_win_t2 (
        .aclk   (aclk),
        .load   (ctrl.lane_ld),
        .count  (t2_cnt_reg),
        .window (t2_win_reg),
        .fail   (win_fail[1])
    );

    ppc_window_lane #(.CB(CB)) u_win_b1 (
        .aclk   (aclk),
        .load   (ctrl.lane_ld),
        .count  (b1_cnt_reg),
        .window (br_win_reg),
        .fail   (win_fail[2])
    );

    ppc_window_lane #(.CB(CB)) u_win_b2 (
        .aclk   (aclk),
        .load   (ctrl.lane_ld),
        .count  (b2_cnt_reg),
        .window (br_win_reg),
        .fail   (win_fail[3])
    );

    // Ratio lanes; the brake window doubles as its span (a flat window gives 0/1 or 1/1)
    ppc_ratio_lane #(.CB(CB)) u_ratio_t1 (
        .aclk  (aclk),
        .load  (ctrl.lane_ld),
        .count (t1_cnt_reg),
        .span  (t1_span_reg),
        .num   (t1_num),
        .den   (t1_den)
    );

    ppc_ratio_lane #(.CB(CB)) u_ratio_t2 (
        .aclk  (aclk),
        .load  (ctrl.lane_ld),
        .count (t2_cnt_reg),
        .span  (t2_span_reg),
        .num   (t2_num),
        .den   (t2_den)
    );

    ppc_ratio_lane #(.CB(CB)) u_ratio_br (
        .aclk  (aclk),
        .load  (ctrl.lane_ld),
        .count (b1_cnt_reg),
        .span  (br_win_reg),
        .num   (br_num),
        .den   (br_den)
    );

    ppc_merge #(.CB(CB)) u_merge (
        .aclk         (aclk),
        .ctrl         (ctrl),
        .win_fail     (win_fail),
        .t1_num       (t1_num),
        .t1_den       (t1_den),
        .t2_num       (t2_num),
        .t2_den       (t2_den),
        .br_num       (br_num),
        .br_den       (br_den),
        .limit_pct    (limit_reg),
        .inhibit_pair (inhibit_reg),
        .recover_pair (recover_reg),
        .latched      (latch_reg),
        .latched_next (latch_next),
        .torque_ok    (torque_ok),
        .status       (status)
    );

    // Inhibit latch advances only when the result is committed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latch_reg <= 1'b0;
        end else if (decide) begin
            latch_reg <= latch_next;
        end
    end

    // Output register
    always_comb begin
        if (decide) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (decide) begin
            torque_reg <= torque_ok;
            status_reg <= status;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_torque_allowed = torque_reg;
    assign m_plaus_status   = status_reg;

endmodule
